/* design/gbs_pkg.sv */
package gbs_pkg;

	localparam int MAX_KEPT  = 64;
	localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W     = $clog2(MAX_KEPT + 1);
	localparam int COORD_W   = 16;
	localparam int CLASS_W   = 7;
	localparam int AREA_W    = 2 * COORD_W;
	localparam int THR_W     = 16;
	localparam int TOTAL_W   = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 4'd1;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [CLASS_W-1:0] cls;
		logic [AREA_W-1:0]  area;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             area;
		logic             issue;
		logic [IDX_W-1:0] rd_idx;
		logic             finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             pipe_busy;
		logic             out_hold;
	} stat_t;

	function automatic logic [COORD_W-1:0] overlap_len(
		input logic [COORD_W-1:0] a0,
		input logic [COORD_W-1:0] a1,
		input logic [COORD_W-1:0] b0,
		input logic [COORD_W-1:0] b1
	);
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

endpackage

/* design/gbs_ctrl.sv */
module gbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output gbs_pkg::cmd_t  cmd,
	input  gbs_pkg::stat_t stat
);
	import gbs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AREA,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_idx;

	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == stat.count);

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.area   = (state_q == S_AREA);
	assign cmd.issue  = (state_q == S_SCAN);
	assign cmd.rd_idx = idx_q;
	assign cmd.finish = (state_q == S_DONE) && !stat.out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_AREA;
					end
				end
				S_AREA: begin
					idx_q   <= '0;
					state_q <= (stat.count == '0) ? S_DRAIN : S_SCAN;
				end
				S_SCAN: begin
					if (last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!stat.out_hold) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/gbs_dp.sv */
module gbs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gbs_pkg::cmd_t                   cmd,
	output gbs_pkg::stat_t                  stat,
	input  logic                            cfg_valid,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            new_frame,
	input  logic [gbs_pkg::COORD_W-1:0]     left_edge,
	input  logic [gbs_pkg::COORD_W-1:0]     top_edge,
	input  logic [gbs_pkg::COORD_W-1:0]     right_edge,
	input  logic [gbs_pkg::COORD_W-1:0]     bottom_edge,
	input  logic [gbs_pkg::CLASS_W-1:0]     class_label,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            keep,
	output logic [gbs_pkg::TOTAL_W-1:0]     kept_total,
	output logic                            table_full
);
	import gbs_pkg::*;

	// configuration
	logic [THR_W-1:0] thr_q;
	logic             agn_q;

	// current box
	logic [COORD_W-1:0] l_q, t_q, r_q, b_q;
	logic [CLASS_W-1:0] lab_q;
	logic [AREA_W-1:0]  area_q;
	logic               supp_q;
	logic [CNT_W-1:0]   cnt_q;

	// kept table
	entry_t mem [MAX_KEPT];

	// compare pipeline
	logic                v1, v2, v3, v4;
	entry_t              rd_s1;
	logic [COORD_W-1:0]  ow_s2, oh_s2;
	logic [AREA_W-1:0]   karea_s2;
	logic [AREA_W-1:0]   inter_s3;
	logic [AREA_W:0]     sum_s3;
	logic [AREA_W-1:0]   inter_s4;
	logic [AREA_W:0]     union_s4;

	logic [AREA_W+THR_W-1:0] lhs;
	logic [AREA_W+THR_W:0]   rhs;
	logic                    overlap_hit;
	logic                    room;
	logic                    keep_now;
	logic [CNT_W-1:0]        cnt_next;
	entry_t                  new_entry;

	assign lhs         = {inter_s4, {THR_W{1'b0}}};
	assign rhs         = thr_q * union_s4;
	assign overlap_hit = v4 && ({1'b0, lhs} > rhs);

	assign room     = (cnt_q < CNT_W'(MAX_KEPT));
	assign keep_now = !supp_q;
	assign cnt_next = (keep_now && room) ? (cnt_q + CNT_W'(1)) : cnt_q;

	assign new_entry = '{left: l_q, top: t_q, right: r_q, bottom: b_q,
		cls: lab_q, area: area_q};

	assign stat.count     = cnt_q;
	assign stat.pipe_busy = v1 | v2 | v3 | v4;
	assign stat.out_hold  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			agn_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IOU_THRESHOLD:  thr_q <= cfg_data[THR_W-1:0];
				REG_CLASS_AGNOSTIC: agn_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// box capture, edges clamped so that width and height never go negative
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q   <= left_edge;
			t_q   <= top_edge;
			r_q   <= (right_edge < left_edge) ? left_edge : right_edge;
			b_q   <= (bottom_edge < top_edge) ? top_edge : bottom_edge;
			lab_q <= class_label;
		end
		if (cmd.area) begin
			area_q <= (r_q - l_q) * (b_q - t_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			supp_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				supp_q <= 1'b0;
				if (new_frame) begin
					cnt_q <= '0;
				end
			end else if (overlap_hit) begin
				supp_q <= 1'b1;
			end
			if (cmd.finish) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && keep_now && room) begin
			mem[cnt_q[IDX_W-1:0]] <= new_entry;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[cmd.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			v1 <= cmd.issue;
			v2 <= v1 && (agn_q || (rd_s1.cls == lab_q));
			v3 <= v2;
			v4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		ow_s2    <= overlap_len(l_q, r_q, rd_s1.left, rd_s1.right);
		oh_s2    <= overlap_len(t_q, b_q, rd_s1.top, rd_s1.bottom);
		karea_s2 <= rd_s1.area;
		inter_s3 <= ow_s2 * oh_s2;
		sum_s3   <= {1'b0, area_q} + {1'b0, karea_s2};
		inter_s4 <= inter_s3;
		union_s4 <= sum_s3 - {1'b0, inter_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			keep       <= keep_now;
			kept_total <= TOTAL_W'(cnt_next);
			table_full <= keep_now && !room;
		end
	end

endmodule

/* design/greedy_box_suppression.sv */
// greedy non-maximum suppression: boxes come in one beat each, already sorted by
// descending score, and each beat gives one result beat saying whether the box
// survives, how many boxes the kept table holds afterwards and whether a survivor
// found the table full. corners are unsigned 12.4, the overlap test is
// inter * 65536 > iou_threshold * union on exact integer areas, so zero-area boxes
// are never suppressed. the kept table is a single-port memory read one entry
// per cycle into a compare pipeline, followed by a drain of that pipeline and
// an append. a new beat is taken while the previous result still waits in the
// output register. the user must write configuration only while the block is
// idle, which the block itself does not enforce; cfg_ready is always high and
// writes to unknown indexes are dropped. new_frame empties the table before
// its box.
module greedy_box_suppression (
	input  logic                          clk,
	input  logic                          arst_n,
	// box input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          new_frame,
	input  logic [gbs_pkg::COORD_W-1:0]   left_edge,
	input  logic [gbs_pkg::COORD_W-1:0]   top_edge,
	input  logic [gbs_pkg::COORD_W-1:0]   right_edge,
	input  logic [gbs_pkg::COORD_W-1:0]   bottom_edge,
	input  logic [gbs_pkg::CLASS_W-1:0]   class_label,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          keep,
	output logic [gbs_pkg::TOTAL_W-1:0]   kept_total,
	output logic                          table_full,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbs_pkg::CFG_W-1:0]     cfg_data
);
	import gbs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// register writes never wait
	assign cfg_ready = 1'b1;

	// sequencer: accept, area, table scan, drain, append and result
	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	// kept table, overlap pipeline, count and output register
	gbs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.new_frame   (new_frame),
		.left_edge   (left_edge),
		.top_edge    (top_edge),
		.right_edge  (right_edge),
		.bottom_edge (bottom_edge),
		.class_label (class_label),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.keep        (keep),
		.kept_total  (kept_total),
		.table_full  (table_full)
	);

`ifndef NO_ASSERTIONS
	// a survivor that found no room cannot have been suppressed
	a_full_implies_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> keep)
		else $error("table_full reported on a suppressed box");

	// an accepted box keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a box beat");

	// a result only appears while a box is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without a box in progress");
`endif

endmodule

/* bench/tb.sv */
module tb;
	import gbs_pkg::*;

	// a whole idle spell can last a full table scan plus the longest gap on both sides
	localparam int QUIET_LIMIT  = 4000;
	// cycles to let pass once nothing is expected, well over the longest item
	localparam int SETTLE_TIME  = 100;
	localparam int SPOTS        = 6;
	// an index the block does not decode, written to check that it is dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

	// one box beat as the sender sees it
	typedef struct packed {
		logic               new_frame;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [CLASS_W-1:0] label;
	} box_t;

	// one result beat
	typedef struct packed {
		logic               keep;
		logic [TOTAL_W-1:0] total;
		logic               full;
	} verdict_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 new_frame   = 1'b0;
	logic [COORD_W-1:0]   left_edge   = '0;
	logic [COORD_W-1:0]   top_edge    = '0;
	logic [COORD_W-1:0]   right_edge  = '0;
	logic [COORD_W-1:0]   bottom_edge = '0;
	logic [CLASS_W-1:0]   class_label = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 keep;
	logic [TOTAL_W-1:0]   kept_total;
	logic                 table_full;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;

	greedy_box_suppression DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.new_frame   (new_frame),
		.left_edge   (left_edge),
		.top_edge    (top_edge),
		.right_edge  (right_edge),
		.bottom_edge (bottom_edge),
		.class_label (class_label),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.keep        (keep),
		.kept_total  (kept_total),
		.table_full  (table_full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// our own copy of the register file, changed only while the block is idle
	logic [THR_W-1:0]   iou_limit = THR_RESET;
	logic               any_label = 1'b0;

	// our own copy of the kept table
	logic [COORD_W-1:0] held_left   [MAX_KEPT];
	logic [COORD_W-1:0] held_top    [MAX_KEPT];
	logic [COORD_W-1:0] held_right  [MAX_KEPT];
	logic [COORD_W-1:0] held_bottom [MAX_KEPT];
	logic [CLASS_W-1:0] held_label  [MAX_KEPT];
	logic [AREA_W-1:0]  held_area   [MAX_KEPT];
	int                 held_count = 0;

	// verdicts worked out for accepted boxes, oldest first
	verdict_t pending_verdicts [$];

	int  fails      = 0;
	int  quiet      = 0;
	bit  in_gaps    = 1'b0;
	bit  out_stalls = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// length shared by two closed intervals, zero when they only touch or miss
	function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] a_lo,
			input logic [COORD_W-1:0] a_hi, input logic [COORD_W-1:0] b_lo,
			input logic [COORD_W-1:0] b_hi);
		int from;
		int upto;
		from = (b_lo > a_lo) ? int'(b_lo) : int'(a_lo);
		upto = (b_hi < a_hi) ? int'(b_hi) : int'(a_hi);
		if (upto <= from)
			return '0;
		return COORD_W'(upto - from);
	endfunction

	// greedy suppression of one box against the kept table, updating the table
	function automatic verdict_t judge_box(input box_t b);
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] bt;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [AREA_W-1:0]  area;
		logic [63:0]        inter;
		logic [63:0]        uni;
		verdict_t           v;
		v.keep = 1'b1;
		v.full = 1'b0;
		if (b.new_frame)
			held_count = 0;
		// a reversed box collapses onto its left or top edge
		r  = (b.right < b.left) ? b.left : b.right;
		bt = (b.bottom < b.top) ? b.top : b.bottom;
		w  = r - b.left;
		h  = bt - b.top;
		area = {{COORD_W{1'b0}}, w} * {{COORD_W{1'b0}}, h};
		for (int j = 0; j < held_count; j++) begin
			if (!any_label && held_label[j] != b.label)
				continue;
			inter = 64'(span(b.left, r, held_left[j], held_right[j])) *
				64'(span(b.top, bt, held_top[j], held_bottom[j]));
			uni = 64'(area) + 64'(held_area[j]) - inter;
			// ratio test without division, so an empty union never suppresses
			if ((inter << 16) > 64'(iou_limit) * uni)
				v.keep = 1'b0;
		end
		if (v.keep) begin
			if (held_count < MAX_KEPT) begin
				held_left[held_count]   = b.left;
				held_top[held_count]    = b.top;
				held_right[held_count]  = r;
				held_bottom[held_count] = bt;
				held_label[held_count]  = b.label;
				held_area[held_count]   = area;
				held_count++;
			end else begin
				v.full = 1'b1;
			end
		end
		v.total = TOTAL_W'(held_count);
		return v;
	endfunction

	function automatic box_t box_of(input logic nf, input logic [COORD_W-1:0] l,
			input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] b, input logic [CLASS_W-1:0] lab);
		box_t bx;
		bx.new_frame = nf;
		bx.left      = l;
		bx.top       = t;
		bx.right     = r;
		bx.bottom    = b;
		bx.label     = lab;
		return bx;
	endfunction

	function automatic logic [COORD_W-1:0] to_coord(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return COORD_W'(v);
	endfunction

	// one box beat; valid is left high so that a following beat runs on without a bubble
	task automatic send_box(input box_t b);
		if (in_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		new_frame   <= b.new_frame;
		left_edge   <= b.left;
		top_edge    <= b.top;
		right_edge  <= b.right;
		bottom_edge <= b.bottom;
		class_label <= b.label;
		do @(posedge clk); while (in_stall);
		pending_verdicts = {pending_verdicts, judge_box(b)};
	endtask

	// stop sending and wait for every outstanding result beat
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// threshold, then a write the block must ignore, then the label mode
	task automatic configure(input logic [THR_W-1:0] thr, input logic agn);
		cfg_valid <= 1'b1;
		cfg_index <= REG_IOU_THRESHOLD;
		cfg_data  <= CFG_W'(thr);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_UNUSED;
		cfg_data  <= CFG_W'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_CLASS_AGNOSTIC;
		cfg_data  <= {(CFG_W-1)'($urandom), agn};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		iou_limit = thr;
		any_label = agn;
	endtask

	// frames of boxes clustered around a few spots, so that suppression is common,
	// with some noise beats that may carry any bit pattern or break a frame
	task automatic run_phase(input logic [THR_W-1:0] thr, input logic agn,
			input int n_boxes, input bit allow_idle);
		int   spot_x [SPOTS];
		int   spot_y [SPOTS];
		int   spot_w [SPOTS];
		int   spot_h [SPOTS];
		int   spot_count;
		int   labels;
		int   remaining;
		int   len;
		int   k;
		int   jx;
		int   jy;
		int   lx;
		int   ty;
		box_t b;
		drain();
		configure(thr, agn);
		in_gaps    = allow_idle && ($urandom_range(0, 3) != 0);
		out_stalls = allow_idle && ($urandom_range(0, 3) != 0);
		remaining  = n_boxes;
		while (remaining > 0) begin
			len = $urandom_range(1, 90);
			if (len > remaining)
				len = remaining;
			spot_count = $urandom_range(1, SPOTS);
			labels     = $urandom_range(1, 4);
			for (int s = 0; s < SPOTS; s++) begin
				spot_x[s] = $urandom_range(0, 65535);
				spot_y[s] = $urandom_range(0, 65535);
				// mostly modest boxes, now and then a huge one
				spot_w[s] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
					: $urandom_range(0, 3000);
				spot_h[s] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
					: $urandom_range(0, 3000);
			end
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					b.new_frame = 1'($urandom);
					b.left      = COORD_W'($urandom);
					b.top       = COORD_W'($urandom);
					b.right     = COORD_W'($urandom);
					b.bottom    = COORD_W'($urandom);
					b.label     = CLASS_W'($urandom);
				end else begin
					k  = $urandom_range(0, spot_count - 1);
					jx = spot_w[k] / 3 + 1;
					jy = spot_h[k] / 3 + 1;
					lx = spot_x[k] + $urandom_range(0, 2 * jx) - jx;
					ty = spot_y[k] + $urandom_range(0, 2 * jy) - jy;
					// jitter on the size may turn a small box inside out
					b.new_frame = (i == 0);
					b.left      = to_coord(lx);
					b.top       = to_coord(ty);
					b.right     = to_coord(lx + spot_w[k] + $urandom_range(0, 2 * jx) - jx);
					b.bottom    = to_coord(ty + spot_h[k] + $urandom_range(0, 2 * jy) - jy);
					b.label     = CLASS_W'($urandom_range(0, labels - 1));
				end
				send_box(b);
			end
			remaining -= len;
		end
	endtask

	// reset register values: same-label suppression, reversed and empty boxes,
	// the corners of the coordinate range and a frame restart
	task automatic test_reset_defaults();
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
		send_box(box_of(1'b1, 0, 0, 160, 160, 0));
		send_box(box_of(1'b0, 0, 0, 160, 160, 0));
		send_box(box_of(1'b0, 0, 0, 160, 160, 5));
		send_box(box_of(1'b0, 40, 0, 200, 160, 0));
		send_box(box_of(1'b0, 100, 0, 260, 160, 0));
		send_box(box_of(1'b0, 1600, 10, 800, 500, 0));
		send_box(box_of(1'b0, 1600, 10, 800, 500, 0));
		send_box(box_of(1'b0, 0, 0, '1, '1, '1));
		send_box(box_of(1'b0, 0, 0, '1, '1, '1));
		send_box(box_of(1'b0, '1, '1, '1, '1, '1));
		send_box(box_of(1'b0, '1, 0, 0, '1, 0));
		send_box(box_of(1'b1, 0, 0, 160, 160, 0));
		drain();
	endtask

	// threshold at both ends of its range, with and without label matching
	task automatic test_threshold_extremes();
		// zero threshold, any label: a single shared pixel suppresses, touching does not
		configure('0, 1'b1);
		send_box(box_of(1'b1, 0, 0, 160, 160, 3));
		send_box(box_of(1'b0, 159, 159, 400, 400, 9));
		send_box(box_of(1'b0, 160, 0, 320, 160, 9));
		drain();
		// full-scale threshold: only an exact copy goes
		configure('1, 1'b0);
		send_box(box_of(1'b1, 0, 0, 160, 160, 2));
		send_box(box_of(1'b0, 0, 0, 160, 160, 2));
		send_box(box_of(1'b0, 0, 0, 160, 159, 2));
		drain();
	endtask

	// survivors beyond the table size are flagged and dropped
	task automatic test_full_table();
		configure(THR_RESET, 1'b1);
		// seventy disjoint tiles, the last six find the table full
		for (int i = 0; i < 70; i++)
			send_box(box_of(i == 0, to_coord(i % 10 * 4000), to_coord(i / 10 * 4000),
				to_coord(i % 10 * 4000 + 3000), to_coord(i / 10 * 4000 + 3000),
				CLASS_W'($urandom)));
		// a copy of the first tile is still suppressed while full
		repeat (2)
			send_box(box_of(1'b0, 0, 0, 3000, 3000, CLASS_W'($urandom)));
		drain();
		// one spot under seventy labels: nothing suppresses across labels
		configure(THR_RESET, 1'b0);
		for (int i = 0; i < 70; i++)
			send_box(box_of(i == 0, 800, 800, 2400, 2400, CLASS_W'(i)));
		drain();
	endtask

	task automatic test_random_frames();
		run_phase(THR_RESET, 1'b0, 150, 1'b1);
		run_phase(THR_RESET, 1'b1, 150, 1'b1);
		run_phase('0, 1'b0, 150, 1'b1);
		run_phase('1, 1'b1, 150, 1'b1);
		run_phase(16'd1, 1'b0, 100, 1'b1);
		repeat (2)
			run_phase(THR_W'($urandom), 1'($urandom), 150, 1'b1);
	endtask

	// the last stretch runs flat out on both sides
	task automatic test_steady_stream();
		run_phase(THR_W'($urandom_range(20000, 40000)), 1'($urandom), 150, 1'b0);
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_threshold_extremes();
		test_full_table();
		test_random_frames();
		test_steady_stream();
		repeat (SETTLE_TIME) @(posedge clk);
		if (fails == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// receiver back-pressure in bursts, switched per phase
	initial begin
		forever begin
			@(posedge clk);
			if (out_stalls && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// every result beat against the oldest waiting verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no box waiting");
				fails++;
			end else begin
				want = pending_verdicts.pop_front();
				if (keep !== want.keep) begin
					$error("keep: expected %0d, actual %0d", want.keep, keep);
					fails++;
				end
				if (kept_total !== want.total) begin
					$error("kept_total: expected %0d, actual %0d", want.total, kept_total);
					fails++;
				end
				if (table_full !== want.full) begin
					$error("table_full: expected %0d, actual %0d", want.full, table_full);
					fails++;
				end
			end
		end
	end

	// a hung block shows as a long run of cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
